// ===== src/ssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // Display geometry, fixed by the widths of the digit fields
    localparam int DIGIT_POSITIONS = 4;
    localparam int POS_W           = $clog2(DIGIT_POSITIONS);
    localparam int SCAN_W          = $clog2(DIGIT_POSITIONS + 1);

    // Transaction operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_BRIGHT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Timer clock selects
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV32   = 3'd3;
    localparam logic [2:0] CS_DIV64   = 3'd4;
    localparam logic [2:0] CS_DIV128  = 3'd5;
    localparam logic [2:0] CS_DIV256  = 3'd6;
    localparam logic [2:0] CS_DIV1024 = 3'd7;

    localparam logic [3:0] LEVEL_MAX = 4'd15;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        digit_position;
        logic [7:0]        segment_pattern;
        logic signed [7:0] brightness_request;
    } in_item_t;

    typedef struct packed {
        logic [7:0] anode_segments;
        logic [3:0] digit_enables_n;
        logic       slot_switched;
    } out_item_t;

    // Scan and dimming state, excluding the digit store
    typedef struct packed {
        logic [9:0]        prescale_count;
        logic [7:0]        timer_count;
        logic [2:0]        clock_select;
        logic [7:0]        repeat_count;
        logic [SCAN_W-1:0] scan_position;
        logic [3:0]        brightness_level;
        logic [7:0]        anode_latch;
        logic [3:0]        enable_latch;
    } scan_state_t;

    typedef struct packed {
        logic [2:0] sel_on;
        logic [2:0] cnt_on;
        logic [2:0] sel_off;
        logic [2:0] cnt_off;
    } level_row_t;

    typedef level_row_t level_table_t [16];

    // On/off time slicing per brightness level
    localparam level_table_t LEVEL_TABLE = '{
        '{CS_DIV64, 3'd1, CS_DIV64,  3'd1}, '{CS_DIV1,  3'd1, CS_DIV128, 3'd1},
        '{CS_DIV1,  3'd1, CS_DIV64,  3'd1}, '{CS_DIV1,  3'd2, CS_DIV64,  3'd1},
        '{CS_DIV1,  3'd3, CS_DIV64,  3'd1}, '{CS_DIV1,  3'd4, CS_DIV64,  3'd1},
        '{CS_DIV1,  3'd5, CS_DIV64,  3'd1}, '{CS_DIV8,  3'd1, CS_DIV64,  3'd1},
        '{CS_DIV8,  3'd1, CS_DIV8,   3'd6}, '{CS_DIV8,  3'd1, CS_DIV32,  3'd1},
        '{CS_DIV8,  3'd3, CS_DIV64,  3'd1}, '{CS_DIV8,  3'd2, CS_DIV32,  3'd1},
        '{CS_DIV8,  3'd3, CS_DIV32,  3'd1}, '{CS_DIV32, 3'd1, CS_DIV32,  3'd1},
        '{CS_DIV32, 3'd1, CS_DIV8,   3'd2}, '{CS_DIV32, 3'd1, CS_STOP,   3'd1}
    };

    // Prescaler low bits that must be zero for a timer tick
    function automatic logic [9:0] prescale_mask(input logic [2:0] sel);
        logic [9:0] mask;
        unique case (sel)
            CS_STOP:    mask = 10'h000;
            CS_DIV1:    mask = 10'h000;
            CS_DIV8:    mask = 10'h007;
            CS_DIV32:   mask = 10'h01F;
            CS_DIV64:   mask = 10'h03F;
            CS_DIV128:  mask = 10'h07F;
            CS_DIV256:  mask = 10'h0FF;
            CS_DIV1024: mask = 10'h3FF;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== src/ssd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssd_step import ssd_pkg::*; (
    input  wire in_item_t                         item,
    input  wire scan_state_t                      cur,
    input  wire logic [DIGIT_POSITIONS-1:0][7:0]  store_cur,
    output      scan_state_t                      nxt,
    output      logic [DIGIT_POSITIONS-1:0][7:0]  store_nxt,
    output      logic                             switched
);

    logic [9:0]        pre_inc;
    logic              divided;
    logic [7:0]        timer_inc;
    logic              overflow;
    logic [7:0]        rep_dec;
    logic              slot_end;
    level_row_t        row;
    logic [SCAN_W-1:0] pos_eff;
    logic              light_step;
    logic [3:0]        all_off;

    // Prescaler, timer and repeat counter chain
    always_comb begin
        pre_inc   = cur.prescale_count + 10'd1;
        divided   = (cur.clock_select != CS_STOP) &&
                    ((pre_inc & prescale_mask(cur.clock_select)) == 10'd0);
        timer_inc = cur.timer_count + 8'd1;
        overflow  = divided && (timer_inc == 8'd0);
        rep_dec   = cur.repeat_count - 8'd1;
        slot_end  = overflow && (rep_dec == 8'd0);
    end

    // Slot end: pick light or pause step
    always_comb begin
        row        = LEVEL_TABLE[cur.brightness_level];
        all_off    = 4'((1 << DIGIT_POSITIONS) - 1);
        pos_eff    = cur.scan_position;
        if ((cur.scan_position >= SCAN_W'(DIGIT_POSITIONS)) && (row.sel_off == CS_STOP)) begin
            pos_eff = '0;
        end
        light_step = (pos_eff < SCAN_W'(DIGIT_POSITIONS));
    end

    // Next state per operation
    always_comb begin
        nxt       = cur;
        store_nxt = store_cur;
        switched  = 1'b0;
        unique case (item.op)
            OP_TICK: begin
                nxt.prescale_count = pre_inc;
                if (divided) begin
                    nxt.timer_count = timer_inc;
                end
                if (overflow) begin
                    nxt.repeat_count = rep_dec;
                end
                if (slot_end) begin
                    switched         = 1'b1;
                    nxt.enable_latch = all_off;
                    if (light_step) begin
                        nxt.clock_select  = row.sel_on;
                        nxt.repeat_count  = {5'd0, row.cnt_on};
                        nxt.scan_position = pos_eff + SCAN_W'(1);
                        if (cur.brightness_level != 4'd0) begin
                            nxt.anode_latch  = store_cur[pos_eff[POS_W-1:0]];
                            nxt.enable_latch = all_off & ~(4'd1 << pos_eff[POS_W-1:0]);
                        end
                    end else begin
                        nxt.clock_select  = row.sel_off;
                        nxt.repeat_count  = {5'd0, row.cnt_off};
                        nxt.scan_position = '0;
                    end
                end
            end
            OP_WRITE: begin
                store_nxt[item.digit_position] = item.segment_pattern;
            end
            OP_BRIGHT: begin
                // Negative clamps to off, above range to full
                if (item.brightness_request[7]) begin
                    nxt.brightness_level = 4'd0;
                end else if (|item.brightness_request[6:4]) begin
                    nxt.brightness_level = LEVEL_MAX;
                end else begin
                    nxt.brightness_level = item.brightness_request[3:0];
                end
            end
            OP_NONE: begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/seven_segment_scan_dimmer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_       in   s_valid / s_ready  s_item (in_item_t): op, position, pattern, brightness
// m_       out  m_valid / m_ready  m_item (out_item_t): anodes, enables, slot switch
//
// One transaction per cycle sustained while m_ready stays high; the result is registered after input
// acceptance (input register, then the single-pass step logic into the result register).
// aresetn is synchronous, active low: counters cleared, select /1, repeat 1,
// brightness 15, digit store blank, all digits off.
// A stalled result holds its register; the input register still takes a new
// transaction when it is empty, and the state advances only as results move on.

module seven_segment_scan_dimmer_unit import ssd_pkg::*; (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_item,
    output logic            m_valid,
    input  wire             m_ready,
    output out_item_t       m_item
);

    in_item_t                        in_item_reg;
    logic                            in_valid_reg;
    scan_state_t                     state_reg;
    scan_state_t                     state_next;
    logic [DIGIT_POSITIONS-1:0][7:0] store_reg;
    logic [DIGIT_POSITIONS-1:0][7:0] store_next;
    logic                            switched;
    out_item_t                       out_item_reg;
    logic                            out_valid_reg;
    logic                            advance;

    // Pipeline flow control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    ssd_step u_step (
        .item      (in_item_reg),
        .cur       (state_reg),
        .store_cur (store_reg),
        .nxt       (state_next),
        .store_nxt (store_next),
        .switched  (switched)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    // Scan state and digit store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prescale_count   <= '0;
            state_reg.timer_count      <= '0;
            state_reg.clock_select     <= CS_DIV1;
            state_reg.repeat_count     <= 8'd1;
            state_reg.scan_position    <= '0;
            state_reg.brightness_level <= LEVEL_MAX;
            state_reg.anode_latch      <= '0;
            state_reg.enable_latch     <= 4'((1 << DIGIT_POSITIONS) - 1);
            store_reg                  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            store_reg <= store_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_item_reg.anode_segments  <= state_next.anode_latch;
            out_item_reg.digit_enables_n <= state_next.enable_latch;
            out_item_reg.slot_switched   <= switched;
        end
    end

endmodule

`default_nettype wire

// ===== dv/seven_segment_scan_dimmer_unit_test.sv =====
`timescale 1ns / 1ps

module seven_segment_scan_dimmer_unit_test import ssd_pkg::*; ();

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 100;
    localparam int SOAK_RUNS    = 2;
    localparam int SOAK_LEN     = 165;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 40_000_000;

    // On and off time slices per brightness level
    typedef struct packed {
        logic [2:0] on_sel;
        logic [7:0] light_reps;
        logic [2:0] off_sel;
        logic [7:0] pause_reps;
    } slice_plan_t;

    localparam slice_plan_t SLICE_PLAN [16] = '{
        '{CS_DIV64, 8'd1, CS_DIV64,  8'd1}, '{CS_DIV1,  8'd1, CS_DIV128, 8'd1},
        '{CS_DIV1,  8'd1, CS_DIV64,  8'd1}, '{CS_DIV1,  8'd2, CS_DIV64,  8'd1},
        '{CS_DIV1,  8'd3, CS_DIV64,  8'd1}, '{CS_DIV1,  8'd4, CS_DIV64,  8'd1},
        '{CS_DIV1,  8'd5, CS_DIV64,  8'd1}, '{CS_DIV8,  8'd1, CS_DIV64,  8'd1},
        '{CS_DIV8,  8'd1, CS_DIV8,   8'd6}, '{CS_DIV8,  8'd1, CS_DIV32,  8'd1},
        '{CS_DIV8,  8'd3, CS_DIV64,  8'd1}, '{CS_DIV8,  8'd2, CS_DIV32,  8'd1},
        '{CS_DIV8,  8'd3, CS_DIV32,  8'd1}, '{CS_DIV32, 8'd1, CS_DIV32,  8'd1},
        '{CS_DIV32, 8'd1, CS_DIV8,   8'd2}, '{CS_DIV32, 8'd1, CS_STOP,   8'd1}
    };

    // Prescaler low bits that must be clear for a timer count, per clock select
    localparam int TICK_SHIFT [8] = '{0, 0, 3, 5, 6, 7, 8, 10};

    // Display predictor and store of expected display results
    class display_scan_scoreboard;
        out_item_t  expected_display_q[$];
        int         mismatch_count;
        logic [9:0] prescale;
        logic [7:0] timer;
        logic [2:0] sel;
        logic [7:0] repeats;
        logic [2:0] scan;
        logic [3:0] level;
        logic [7:0] digits [DIGIT_POSITIONS];
        logic [7:0] anodes;
        logic [3:0] enables_n;

        function new();
            mismatch_count = 0;
            prescale  = '0;
            timer     = '0;
            sel       = CS_DIV1;
            repeats   = 8'd1;
            scan      = '0;
            level     = LEVEL_MAX;
            anodes    = '0;
            enables_n = '1;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function void predict_display(in_item_t item);
            out_item_t   want;
            slice_plan_t plan;
            logic [9:0]  mask;
            want.slot_switched = 1'b0;
            case (item.op)
                OP_TICK: begin
                    prescale = prescale + 10'd1;
                    mask = (10'd1 << TICK_SHIFT[sel]) - 10'd1;
                    if (sel != CS_STOP && (prescale & mask) == 10'd0) begin
                        timer = timer + 8'd1;
                        if (timer == 8'd0) begin
                            repeats = repeats - 8'd1;
                            if (repeats == 8'd0) begin
                                // slot ends: blank, then light the next digit or pause
                                plan = SLICE_PLAN[level];
                                want.slot_switched = 1'b1;
                                enables_n = '1;
                                if (scan >= DIGIT_POSITIONS && plan.off_sel == CS_STOP)
                                    scan = '0;
                                if (scan < DIGIT_POSITIONS) begin
                                    sel     = plan.on_sel;
                                    repeats = plan.light_reps;
                                    if (level != 4'd0) begin
                                        anodes = digits[scan[POS_W-1:0]];
                                        enables_n[scan[POS_W-1:0]] = 1'b0;
                                    end
                                    scan = scan + 3'd1;
                                end else begin
                                    sel     = plan.off_sel;
                                    repeats = plan.pause_reps;
                                    scan    = '0;
                                end
                            end
                        end
                    end
                end
                OP_WRITE: digits[item.digit_position] = item.segment_pattern;
                OP_BRIGHT: begin
                    // clamp to 0..15: negative gives dark, above range gives full
                    if (item.brightness_request[7])
                        level = 4'd0;
                    else if (item.brightness_request[6:4] != 3'd0)
                        level = LEVEL_MAX;
                    else
                        level = item.brightness_request[3:0];
                end
                default: ;
            endcase
            want.anode_segments  = anodes;
            want.digit_enables_n = enables_n;
            expected_display_q.push_back(want);
        endfunction

        function void check_display(out_item_t got);
            out_item_t want;
            if (expected_display_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: seg=%02h en=%01h sw=%0b",
                             got.anode_segments, got.digit_enables_n, got.slot_switched);
                mismatch_count++;
                return;
            end
            want = expected_display_q.pop_front();
            if (got.anode_segments !== want.anode_segments ||
                got.digit_enables_n !== want.digit_enables_n ||
                got.slot_switched !== want.slot_switched) begin
                if (mismatch_count < 10)
                    $display("mismatch: expected seg=%02h en=%01h sw=%0b, got seg=%02h en=%01h sw=%0b",
                             want.anode_segments, want.digit_enables_n, want.slot_switched,
                             got.anode_segments, got.digit_enables_n, got.slot_switched);
                mismatch_count++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    bit idle_allowed = 1'b1;
    bit source_gaps  = 1'b1;

    display_scan_scoreboard scoreboard = new();

    seven_segment_scan_dimmer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic in_item_t make_item(input logic [1:0] op, input logic [1:0] pos,
                                           input logic [7:0] pattern,
                                           input logic [7:0] request);
        in_item_t item;
        item.op                 = op;
        item.digit_position     = pos;
        item.segment_pattern    = pattern;
        item.brightness_request = request;
        return item;
    endfunction

    // Offer one transaction, with an occasional gap first, and wait for acceptance
    task automatic present_transaction(input in_item_t item);
        if (idle_allowed && source_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_item  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        scoreboard.predict_display(item);
    endtask

    // Random item with any op, spare fields filled with junk
    task automatic present_random(input int tick_pct, input int write_pct,
                                  input int bright_pct);
        logic [1:0] op;
        logic [7:0] request;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < tick_pct)
            op = OP_TICK;
        else if (pick < tick_pct + write_pct)
            op = OP_WRITE;
        else if (pick < tick_pct + write_pct + bright_pct)
            op = OP_BRIGHT;
        else
            op = OP_NONE;
        // half the requests near the legal range, the rest anywhere
        request = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 17))
                                              : 8'($urandom_range(0, 255));
        present_transaction(make_item(op, 2'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255)), request));
    endtask

    // Result sink: ready stalls in bursts while idling is allowed
    initial begin
        m_ready <= 1'b0;
        forever begin
            if (idle_allowed && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scoreboard.check_display(m_item);
    end

    // Stimulus
    initial begin
        logic signed [7:0] soak_request [SOAK_RUNS];
        int                pick;
        logic [1:0]        op;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: pattern extremes, every op, clamp edges
        present_transaction(make_item(OP_WRITE, 2'd0, 8'hFF, 8'h00));
        present_transaction(make_item(OP_WRITE, 2'd1, 8'h00, 8'hFF));
        present_transaction(make_item(OP_WRITE, 2'd2, 8'hA5, 8'h00));
        present_transaction(make_item(OP_WRITE, 2'd3, 8'h5A, 8'h00));
        present_transaction(make_item(OP_TICK, 2'd3, 8'hFF, 8'hFF));
        present_transaction(make_item(OP_NONE, 2'd3, 8'hFF, 8'hFF));
        present_transaction(make_item(OP_NONE, 2'd0, 8'h00, 8'h00));
        present_transaction(make_item(OP_BRIGHT, 2'd0, 8'h00, 8'h80));
        present_transaction(make_item(OP_BRIGHT, 2'd3, 8'hFF, 8'h7F));
        present_transaction(make_item(OP_BRIGHT, 2'd0, 8'h00, 8'h10));
        present_transaction(make_item(OP_BRIGHT, 2'd0, 8'h00, 8'h00));
        present_transaction(make_item(OP_BRIGHT, 2'd0, 8'h00, 8'hFF));
        present_transaction(make_item(OP_BRIGHT, 2'd1, 8'h00, 8'h01));
        present_transaction(make_item(OP_BRIGHT, 2'd2, 8'h00, 8'h0F));
        present_transaction(make_item(OP_TICK, 2'd0, 8'h00, 8'h00));
        present_transaction(make_item(OP_WRITE, 2'd3, 8'hFF, 8'h80));

        // Random mix, gaps switched on and off in stretches
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0)
                source_gaps = ($urandom_range(0, 2) != 0);
            present_random(55, 20, 15);
        end

        // Tick runs at chosen levels; the timer first overflows here, so a slot
        // ends, a digit lights and the level's on slice is loaded
        soak_request = '{8'sd100, 8'sd0};
        soak_request[1] = 8'($urandom_range(1, 6));
        for (int run = 0; run < SOAK_RUNS; run++) begin
            idle_allowed = (run < 1);
            source_gaps  = 1'b1;
            present_transaction(make_item(OP_BRIGHT, 2'($urandom_range(0, 3)),
                                          8'($urandom_range(0, 255)), soak_request[run]));
            for (int t = 0; t < SOAK_LEN; t++) begin
                // mostly ticks; rare writes and level changes land mid-slot
                pick = $urandom_range(0, 4999);
                if (pick < 20)
                    op = OP_WRITE;
                else if (pick == 20)
                    op = OP_NONE;
                else if (pick == 21)
                    op = OP_BRIGHT;
                else
                    op = OP_TICK;
                present_transaction(make_item(op, 2'($urandom_range(0, 3)),
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255))));
            end
        end

        // Drain
        s_valid <= 1'b0;
        while (scoreboard.expected_display_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.mismatch_count == 0 && scoreboard.expected_display_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ssd_pkg.sv
src/ssd_step.sv
src/seven_segment_scan_dimmer_unit.sv
dv/seven_segment_scan_dimmer_unit_test.sv
